/* rtl/deque_with_digit_filter_assert.svh */
// Assertion macros for the deque with digit filter.
// Used by the top level; relies on i_clk and i_rst_n in the including module.
`ifndef DEQUE_WITH_DIGIT_FILTER_ASSERT_SVH
`define DEQUE_WITH_DIGIT_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DWDF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DWDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dwdf_pkg.sv */
// Shared types, codes and helper functions for the deque with digit filter.
// No dependencies; used by the controller, the datapath and the top level.
package dwdf_pkg;

    // Command codes of an input item.
    localparam logic [2:0] CMD_RESTART    = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [2:0] CMD_READ_FWD   = 3'd3;
    localparam logic [2:0] CMD_READ_BWD   = 3'd4;
    localparam logic [2:0] CMD_REMOVE     = 3'd5;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Where the output register takes its value and status from.
    typedef enum logic [2:0] {
        SRC_OK,
        SRC_FULL,
        SRC_EMPTY,
        SRC_MEM,
        SRC_COUNT
    } t_src_e;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   latch;
        logic   op_restart;
        logic   op_push_front;
        logic   op_push_back;
        logic   walk_start;
        logic   walk_step;
        logic   rm_active;
        logic   rm_commit;
        logic   out_load;
        t_src_e out_src;
        logic   out_last;
    } t_dp_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] cmd;
        logic       full;
        logic       empty;
        logic       walk_last;
        logic       out_free;
    } t_dp_stat;

    // True when a value is non-negative and its remainder by ten is five.
    // Since 16 mod 5 is 1, the nibble sum has the same remainder by five;
    // folding that sum once more gives a value of at most 22.
    function automatic logic f_ends_in_five(input logic [31:0] v);
        logic [6:0] s;
        logic [4:0] f;
        s = '0;
        for (int k = 0; k < 8; k++) begin
            s = s + 7'(v[4*k +: 4]);
        end
        f = 5'(s[6:4]) + 5'(s[3:0]);
        return !v[31] && v[0] &&
               (f == 5'd0 || f == 5'd5 || f == 5'd10 || f == 5'd15 || f == 5'd20);
    endfunction

endpackage

/* rtl/deque_with_digit_filter.sv */
// Channel | Handshake                   | Payload
// --------+-----------------------------+----------------------------------
// input   | i_in_valid / o_in_ready     | i_cmd, i_value
// output  | o_out_valid / i_out_ready   | o_value_res, o_status, o_last
//
// Restart and push each give one result. A read-out gives one element per cycle, while
// the output is not stalled, from the single read port (an empty status when empty);
// removal gives one result, and unused codes give no result.
// The next item is accepted once the sequencer is idle again, while the last result
// may still wait in the output register. Reset (synchronous, active low) empties
// the queue but leaves the slot memory uncleared; output stalls hold the walk in place.
//
// Top level of the deque with digit filter; depends on dwdf_pkg, dwdf_ctrl,
// dwdf_datapath and deque_with_digit_filter_assert.svh.
`include "deque_with_digit_filter_assert.svh"

module deque_with_digit_filter #(
    parameter int DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_value_res,
    output logic [1:0]         o_status,
    output logic               o_last
);

    dwdf_pkg::t_dp_ctl  ctl;
    dwdf_pkg::t_dp_stat stat;

    dwdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    dwdf_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value_res (o_value_res),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    // A result is loaded only when the previous one has been taken.
    `DWDF_ASSERT_SAME(a_load_when_free, ctl.out_load, stat.out_free, "result overwritten")

    // The walk never steps beyond the last stored element.
    `DWDF_ASSERT_SAME(a_walk_bound, ctl.walk_step, !stat.walk_last, "walk past end")

    // At most one user of the memory write port in a cycle.
    `DWDF_ASSERT_SAME(a_one_writer, 1'b1,
        $onehot0({ctl.op_restart, ctl.op_push_front, ctl.op_push_back, ctl.rm_active}),
        "write port conflict")

    // An accepted item keeps the block busy in the following cycle.
    `DWDF_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready,
        "item accepted while busy")

endmodule

/* rtl/dwdf_datapath.sv */
// Datapath of the deque: slot memory, ring pointers, walk counters, output register.
// Depends on dwdf_pkg; driven by dwdf_ctrl through t_dp_ctl.
module dwdf_datapath #(
    parameter int DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dwdf_pkg::t_dp_ctl   i_ctl,
    output dwdf_pkg::t_dp_stat  o_stat,
    input  logic [2:0]          i_cmd,
    input  logic signed [31:0]  i_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_value_res,
    output logic [1:0]          o_status,
    output logic                o_last
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_W = SW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

    // Slot position of an offset from the front; one compare and subtract.
    function automatic logic [IW-1:0] f_ring(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[IW-1:0];
    endfunction

    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_rd_data;
    logic [2:0]    r_cmd;
    logic [31:0]   r_value;
    logic [IW-1:0] r_front;
    logic [CW-1:0] r_occ;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_kept;
    logic [CW-1:0] r_count;
    logic          r_out_valid;
    logic [31:0]   r_out_val;
    logic [1:0]    r_out_status;
    logic          r_out_last;

    logic [CW-1:0] n_i;
    logic [CW-1:0] rd_off;
    logic [IW-1:0] rd_addr;
    logic          rd_en;
    logic [IW-1:0] front_dec;
    logic          keep;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          out_free;

    // Walk index and the read address it selects, front to back or back to front.
    assign n_i     = i_ctl.walk_start ? '0 : r_i + CW'(1);
    assign rd_off  = (r_cmd == dwdf_pkg::CMD_READ_BWD) ? (r_occ - CW'(1) - n_i) : n_i;
    assign rd_addr = f_ring(r_front, rd_off);
    assign rd_en   = i_ctl.walk_start || i_ctl.walk_step;

    assign front_dec = (r_front == '0) ? LAST_SLOT : r_front - IW'(1);
    assign keep      = !dwdf_pkg::f_ends_in_five(r_rd_data);
    assign out_free  = !r_out_valid || i_out_ready;

    // Single write port: restart, pushes, and compaction during removal.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_value;
        if (i_ctl.op_restart) begin
            wr_en   = 1'b1;
        end else if (i_ctl.op_push_front) begin
            wr_en   = 1'b1;
            wr_addr = front_dec;
        end else if (i_ctl.op_push_back) begin
            wr_en   = 1'b1;
            wr_addr = f_ring(r_front, r_occ);
        end else if (i_ctl.rm_active && keep) begin
            wr_en   = 1'b1;
            wr_addr = f_ring(r_front, r_kept);
            wr_data = r_rd_data;
        end
    end

    // Slot memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Latched item and walk counters.
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd   <= i_cmd;
            r_value <= i_value;
        end
        if (rd_en) begin
            r_i <= n_i;
        end
        if (i_ctl.walk_start) begin
            r_kept <= '0;
        end else if (i_ctl.rm_active && keep) begin
            r_kept <= r_kept + CW'(1);
        end
        if (i_ctl.rm_commit) begin
            r_count <= r_occ - r_kept;
        end
    end

    // Ring pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_occ   <= '0;
        end else if (i_ctl.op_restart) begin
            r_front <= '0;
            r_occ   <= CW'(1);
        end else if (i_ctl.op_push_front) begin
            r_front <= front_dec;
            r_occ   <= r_occ + CW'(1);
        end else if (i_ctl.op_push_back) begin
            r_occ   <= r_occ + CW'(1);
        end else if (i_ctl.rm_commit) begin
            r_occ   <= r_kept;
        end
    end

    // Output register; a new result loads only when the old one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_last <= i_ctl.out_last;
            case (i_ctl.out_src)
                dwdf_pkg::SRC_MEM: begin
                    r_out_val    <= r_rd_data;
                    r_out_status <= dwdf_pkg::ST_OK;
                end
                dwdf_pkg::SRC_COUNT: begin
                    r_out_val    <= 32'(r_count);
                    r_out_status <= dwdf_pkg::ST_OK;
                end
                dwdf_pkg::SRC_FULL: begin
                    r_out_val    <= '0;
                    r_out_status <= dwdf_pkg::ST_FULL;
                end
                dwdf_pkg::SRC_EMPTY: begin
                    r_out_val    <= '0;
                    r_out_status <= dwdf_pkg::ST_EMPTY;
                end
                default: begin
                    r_out_val    <= '0;
                    r_out_status <= dwdf_pkg::ST_OK;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value_res = r_out_val;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

    assign o_stat.cmd       = r_cmd;
    assign o_stat.full      = (r_occ == DEPTH_C);
    assign o_stat.empty     = (r_occ == '0);
    assign o_stat.walk_last = (r_i == r_occ - CW'(1));
    assign o_stat.out_free  = out_free;

endmodule

/* rtl/dwdf_ctrl.sv */
// Controller of the deque: decodes each item and sequences reads, pushes and removal.
// Depends on dwdf_pkg; talks to dwdf_datapath through t_dp_ctl and t_dp_stat.
module dwdf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dwdf_pkg::t_dp_stat  i_stat,
    output dwdf_pkg::t_dp_ctl   o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RESP,
        S_READ,
        S_RM,
        S_RM_END
    } t_state_e;

    t_state_e          r_state;
    t_state_e          n_state;
    dwdf_pkg::t_src_e  r_src;
    dwdf_pkg::t_src_e  n_src;

    // Next state and the commands of the current state.
    always_comb begin
        n_state    = r_state;
        n_src      = r_src;
        o_ctl      = '0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.cmd) inside
                    dwdf_pkg::CMD_RESTART: begin
                        o_ctl.op_restart = 1'b1;
                        n_src            = dwdf_pkg::SRC_OK;
                        n_state          = S_RESP;
                    end
                    dwdf_pkg::CMD_PUSH_FRONT: begin
                        o_ctl.op_push_front = !i_stat.full;
                        n_src   = i_stat.full ? dwdf_pkg::SRC_FULL : dwdf_pkg::SRC_OK;
                        n_state = S_RESP;
                    end
                    dwdf_pkg::CMD_PUSH_BACK: begin
                        o_ctl.op_push_back = !i_stat.full;
                        n_src   = i_stat.full ? dwdf_pkg::SRC_FULL : dwdf_pkg::SRC_OK;
                        n_state = S_RESP;
                    end
                    dwdf_pkg::CMD_READ_FWD, dwdf_pkg::CMD_READ_BWD: begin
                        if (i_stat.empty) begin
                            n_src   = dwdf_pkg::SRC_EMPTY;
                            n_state = S_RESP;
                        end else begin
                            o_ctl.walk_start = 1'b1;
                            n_state          = S_READ;
                        end
                    end
                    dwdf_pkg::CMD_REMOVE: begin
                        o_ctl.walk_start = 1'b1;
                        n_src            = dwdf_pkg::SRC_COUNT;
                        n_state          = i_stat.empty ? S_RM_END : S_RM;
                    end
                    default: begin
                        // Unused codes cause no result.
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                if (i_stat.out_free) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_src  = dwdf_pkg::SRC_MEM;
                    o_ctl.out_last = i_stat.walk_last;
                    if (i_stat.walk_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ctl.walk_step = 1'b1;
                    end
                end
            end
            S_RM: begin
                o_ctl.rm_active = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_RM_END;
                end else begin
                    o_ctl.walk_step = 1'b1;
                end
            end
            S_RM_END: begin
                o_ctl.rm_commit = 1'b1;
                n_state         = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_src  = r_src;
                    o_ctl.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and the registered result source.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_src   <= dwdf_pkg::SRC_OK;
        end else begin
            r_state <= n_state;
            r_src   <= n_src;
        end
    end

endmodule

/* tb/tb_deque_with_digit_filter.sv */
// Self-checking testbench for the deque with digit filter: directed and random commands
// are checked against a cycle-free model of the queue, item by item, on the output channel.
// Depends on dwdf_pkg and the deque_with_digit_filter top level.
`timescale 1ns / 100ps

module tb_deque_with_digit_filter;

    localparam int DEPTH = 32;

    // Command codes that the block ignores.
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    // Cycles allowed after the last expected item for a dropped command to finish.
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic signed [31:0] value_res;
        logic [1:0]         status;
        logic               last;
    } t_result;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [2:0]         i_cmd       = dwdf_pkg::CMD_RESTART;
    logic signed [31:0] i_value     = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_value_res;
    logic [1:0]         o_status;
    logic               o_last;

    // Model state of the queue.
    logic signed [31:0] ring_slots [DEPTH];
    int                 ring_front = 0;
    int                 ring_count = 0;

    t_result expected_results[$];
    t_result got_result;
    t_result want_result;
    int      err_count      = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      hold_left      = 0;

    deque_with_digit_filter #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cmd      (i_cmd),
        .i_value    (i_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_value_res(o_value_res),
        .o_status   (o_status),
        .o_last     (o_last)
    );

    always #10 i_clk = ~i_clk;

    // Ends the run if the block hangs.
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // The long receiver hold-off counts itself down here.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Drive the output ready and compare each accepted item with the oldest expectation.
    always @(posedge i_clk) begin
        i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_result = '{o_value_res, o_status, o_last};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected item: value_res %0d status %0d last %0d",
                         $time, o_value_res, o_status, o_last);
                err_count++;
            end else begin
                want_result = expected_results.pop_front();
                if (got_result.value_res !== want_result.value_res) begin
                    $display("%0t: value_res expected %0d got %0d",
                             $time, want_result.value_res, got_result.value_res);
                    err_count++;
                end
                if (got_result.status !== want_result.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want_result.status, got_result.status);
                    err_count++;
                end
                if (got_result.last !== want_result.last) begin
                    $display("%0t: last expected %0d got %0d",
                             $time, want_result.last, got_result.last);
                    err_count++;
                end
            end
        end
    end

    function automatic void expect_result(input logic signed [31:0] value_res,
                                          input logic [1:0] status, input logic last);
        expected_results.push_back('{value_res, status, last});
    endfunction

    // Apply one command to the model queue and queue up the items it must produce.
    function automatic void deque_predict(input logic [2:0] cmd,
                                          input logic signed [31:0] val);
        int                 i;
        int                 off;
        int                 kept;
        logic signed [31:0] v;
        case (cmd) inside
            dwdf_pkg::CMD_RESTART: begin
                ring_front    = 0;
                ring_count    = 1;
                ring_slots[0] = val;
                expect_result('0, dwdf_pkg::ST_OK, 1'b1);
            end
            dwdf_pkg::CMD_PUSH_FRONT, dwdf_pkg::CMD_PUSH_BACK: begin
                if (ring_count >= DEPTH) begin
                    expect_result('0, dwdf_pkg::ST_FULL, 1'b1);
                end else begin
                    if (cmd == dwdf_pkg::CMD_PUSH_FRONT) begin
                        ring_front = (ring_front + DEPTH - 1) % DEPTH;
                        ring_slots[ring_front] = val;
                    end else begin
                        ring_slots[(ring_front + ring_count) % DEPTH] = val;
                    end
                    ring_count++;
                    expect_result('0, dwdf_pkg::ST_OK, 1'b1);
                end
            end
            dwdf_pkg::CMD_READ_FWD, dwdf_pkg::CMD_READ_BWD: begin
                if (ring_count == 0) begin
                    expect_result('0, dwdf_pkg::ST_EMPTY, 1'b1);
                end else begin
                    for (i = 0; i < ring_count; i++) begin
                        off = (cmd == dwdf_pkg::CMD_READ_FWD) ? i : ring_count - 1 - i;
                        expect_result(ring_slots[(ring_front + off) % DEPTH],
                                      dwdf_pkg::ST_OK, i == ring_count - 1);
                    end
                end
            end
            dwdf_pkg::CMD_REMOVE: begin
                // Compact the kept values toward the front, keeping their order.
                kept = 0;
                for (i = 0; i < ring_count; i++) begin
                    v = ring_slots[(ring_front + i) % DEPTH];
                    if (v[31] || ($unsigned(v) % 32'd10) != 32'd5) begin
                        ring_slots[(ring_front + kept) % DEPTH] = v;
                        kept++;
                    end
                end
                expect_result(ring_count - kept, dwdf_pkg::ST_OK, 1'b1);
                ring_count = kept;
            end
            default: begin
            end
        endcase
    endfunction

    // Offer one item, wait for it to be accepted, then idle at random.
    task automatic send_item(input logic [2:0] cmd, input logic signed [31:0] val);
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_value    <= val;
        do begin
            @(posedge i_clk);
        end while (!(i_in_valid && o_in_ready));
        deque_predict(cmd, val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // A non-negative value whose last decimal digit is five.
    function automatic logic signed [31:0] five_value();
        return $urandom_range(214748363) * 10 + 5;
    endfunction

    // Mix of plain random values, values ending in five of either sign and extremes.
    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return five_value();
            7:          return -($urandom_range(214748364) * 10 + 5);
            8: begin
                case ($urandom_range(5))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7FFF_FFFF;
                    2:       return 32'sd0;
                    3:       return -32'sd1;
                    4:       return 32'sd5;
                    default: return -32'sd5;
                endcase
            end
            default:    return $urandom_range(99);
        endcase
    endfunction

    // Empty read-outs, push before any restart, extremes, sign rule of the filter,
    // ignored codes and removal of every element.
    task automatic test_directed();
        send_item(dwdf_pkg::CMD_READ_FWD, 32'sd0);
        send_item(dwdf_pkg::CMD_READ_BWD, 32'sd0);
        send_item(dwdf_pkg::CMD_REMOVE, 32'sd0);
        send_item(dwdf_pkg::CMD_PUSH_FRONT, 32'sd5);
        send_item(dwdf_pkg::CMD_PUSH_BACK, -32'sd5);
        send_item(dwdf_pkg::CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_item(dwdf_pkg::CMD_PUSH_BACK, 32'sh8000_0000);
        send_item(dwdf_pkg::CMD_PUSH_BACK, 32'sd2147483645);
        send_item(dwdf_pkg::CMD_PUSH_FRONT, 32'sd0);
        send_item(dwdf_pkg::CMD_PUSH_BACK, -32'sd1);
        send_item(dwdf_pkg::CMD_READ_FWD, 32'sd0);
        send_item(dwdf_pkg::CMD_READ_BWD, -32'sd1);
        send_item(CMD_SPARE_6, 32'sd15);
        send_item(CMD_SPARE_7, -32'sd1);
        send_item(dwdf_pkg::CMD_REMOVE, 32'sd0);
        send_item(dwdf_pkg::CMD_READ_FWD, 32'sd0);
        send_item(dwdf_pkg::CMD_RESTART, 32'sd15);
        send_item(dwdf_pkg::CMD_REMOVE, 32'sd0);
        send_item(dwdf_pkg::CMD_READ_FWD, 32'sd0);
        send_item(dwdf_pkg::CMD_RESTART, 32'sd25);
        send_item(dwdf_pkg::CMD_PUSH_BACK, 32'sd35);
        send_item(dwdf_pkg::CMD_REMOVE, 32'sd0);
        send_item(dwdf_pkg::CMD_READ_BWD, 32'sd0);
    endtask

    // Fill the queue from both ends, have pushes refused, and empty a full queue at once.
    task automatic test_fill_and_refuse();
        int i;
        send_item(dwdf_pkg::CMD_RESTART, rand_value());
        for (i = 0; i < DEPTH - 1; i++) begin
            send_item((i % 2) ? dwdf_pkg::CMD_PUSH_FRONT : dwdf_pkg::CMD_PUSH_BACK,
                      rand_value());
        end
        send_item(dwdf_pkg::CMD_PUSH_FRONT, rand_value());
        send_item(dwdf_pkg::CMD_PUSH_BACK, rand_value());
        send_item(dwdf_pkg::CMD_READ_FWD, rand_value());
        send_item(dwdf_pkg::CMD_READ_BWD, rand_value());
        send_item(dwdf_pkg::CMD_REMOVE, rand_value());
        send_item(dwdf_pkg::CMD_READ_FWD, rand_value());
        send_item(dwdf_pkg::CMD_RESTART, 32'sd5);
        for (i = 0; i < DEPTH - 1; i++) begin
            send_item((i % 3) ? dwdf_pkg::CMD_PUSH_BACK : dwdf_pkg::CMD_PUSH_FRONT,
                      five_value());
        end
        send_item(dwdf_pkg::CMD_REMOVE, rand_value());
        send_item(dwdf_pkg::CMD_READ_BWD, rand_value());
        send_item(dwdf_pkg::CMD_PUSH_BACK, rand_value());
        send_item(dwdf_pkg::CMD_READ_FWD, rand_value());
    endtask

    // Hold the output off for a long stretch while a full queue is read out,
    // so the block stalls its input with items still offered.
    task automatic test_backpressure();
        int i;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(dwdf_pkg::CMD_RESTART, rand_value());
        for (i = 0; i < DEPTH - 1; i++) begin
            send_item(dwdf_pkg::CMD_PUSH_BACK, rand_value());
        end
        hold_left <= HOLD_CYCLES;
        send_item(dwdf_pkg::CMD_READ_FWD, rand_value());
        send_item(dwdf_pkg::CMD_READ_BWD, rand_value());
        send_item(dwdf_pkg::CMD_PUSH_FRONT, rand_value());
        send_item(dwdf_pkg::CMD_REMOVE, rand_value());
        send_item(dwdf_pkg::CMD_READ_FWD, rand_value());
    endtask

    // Random command mix; ignored codes do not count toward the item number.
    task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
        int         done_items;
        int         r;
        logic [2:0] cmd;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        done_items     = 0;
        while (done_items < n_items) begin
            r = $urandom_range(99);
            if (r < 28) begin
                cmd = dwdf_pkg::CMD_PUSH_BACK;
            end else if (r < 52) begin
                cmd = dwdf_pkg::CMD_PUSH_FRONT;
            end else if (r < 65) begin
                cmd = dwdf_pkg::CMD_READ_FWD;
            end else if (r < 76) begin
                cmd = dwdf_pkg::CMD_READ_BWD;
            end else if (r < 88) begin
                cmd = dwdf_pkg::CMD_REMOVE;
            end else if (r < 96) begin
                cmd = dwdf_pkg::CMD_RESTART;
            end else begin
                cmd = $urandom_range(1) ? CMD_SPARE_7 : CMD_SPARE_6;
            end
            send_item(cmd, rand_value());
            if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7) begin
                done_items++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 26;
        recv_stall_pct = 26;
        test_directed();
        test_fill_and_refuse();
        test_backpressure();
        test_random(65, 0, 0);
        test_random(65, 46, 0);
        test_random(65, 0, 46);
        test_random(65, 26, 26);
        i_in_valid <= 1'b0;

        // Let every expected item arrive, then watch for stray ones.
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/dwdf_pkg.sv
rtl/dwdf_datapath.sv
rtl/dwdf_ctrl.sv
rtl/deque_with_digit_filter.sv
tb/tb_deque_with_digit_filter.sv
